FILE: hw/rtl/differential_drive_odometry_unit_macros.svh
// ----------------------------------------------------------------------------
// Odometry assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_MACROS_SVH

// same-cycle implication
`define ODO_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry check failed");

// next-cycle implication
`define ODO_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

`endif

FILE: hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// Odometry package
// Types, constants and the sequencer program shared by the odometry modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

	localparam int DEF_COUNT_BITS    = 32;
	localparam int DEF_POS_FRAC_BITS = 16;

	localparam int POS_W  = 40;
	localparam int ANG_W  = 32;
	localparam int CFG_W  = 24;

	localparam logic [CFG_W-1:0] MPT_RESET = 24'd42425;
	localparam logic [CFG_W-1:0] APM_RESET = 24'd3210176;

	localparam logic REG_MPT = 1'b0;
	localparam logic REG_APM = 1'b1;

	// pi/2 in Q1.30
	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

	// floor(2^34 / d) reciprocals for the series divisions
	localparam logic [31:0] RECIP_42 = 32'((64'd1 << 34) / 42);
	localparam logic [31:0] RECIP_20 = 32'((64'd1 << 34) / 20);
	localparam logic [31:0] RECIP_6  = 32'((64'd1 << 34) / 6);
	localparam logic [31:0] RECIP_56 = 32'((64'd1 << 34) / 56);
	localparam logic [31:0] RECIP_30 = 32'((64'd1 << 34) / 30);
	localparam logic [31:0] RECIP_12 = 32'((64'd1 << 34) / 12);

	localparam logic [5:0] SEQ_LAST = 6'd35;

	typedef enum logic [4:0] {
		U_NOP, U_ML, U_MR, U_DS, U_P0, U_P1, U_MID, U_A, U_A2, U_A2L,
		U_DMA2, U_DMP, U_FXS, U_FXC, U_MA2S, U_MA2C, U_MAS, U_SLD, U_CLAST,
		U_QUAD, U_XH, U_XL, U_XA, U_YH, U_YL, U_YA
	} uop_t;

	typedef enum logic [2:0] {
		D_42, D_20, D_6, D_56, D_30, D_12
	} dsel_t;

	typedef struct packed {
		uop_t  uop;
		dsel_t dsel;
	} step_t;

	typedef struct packed {
		logic  start;
		logic  out_load;
		step_t step;
	} cmd_t;

	function automatic logic [5:0] div_const(input dsel_t sel);
		logic [5:0] d;
		unique case (sel)
			D_42:    d = 6'd42;
			D_20:    d = 6'd20;
			D_6:     d = 6'd6;
			D_56:    d = 6'd56;
			D_30:    d = 6'd30;
			D_12:    d = 6'd12;
			default: d = 6'd42;
		endcase
		return d;
	endfunction

	function automatic logic [31:0] recip(input dsel_t sel);
		logic [31:0] m;
		unique case (sel)
			D_42:    m = RECIP_42;
			D_20:    m = RECIP_20;
			D_6:     m = RECIP_6;
			D_56:    m = RECIP_56;
			D_30:    m = RECIP_30;
			D_12:    m = RECIP_12;
			default: m = RECIP_42;
		endcase
		return m;
	endfunction

	// sequencer program for one update item
	function automatic step_t seq_step(input logic [5:0] idx);
		step_t s;
		s.dsel = D_42;
		unique case (idx)
			6'd0:    s.uop = U_ML;
			6'd1:    s.uop = U_MR;
			6'd2:    s.uop = U_DS;
			6'd3:    s.uop = U_P0;
			6'd4:    s.uop = U_P1;
			6'd5:    s.uop = U_MID;
			6'd6:    s.uop = U_A;
			6'd7:    s.uop = U_A2;
			6'd8:    s.uop = U_A2L;
			6'd9:    s.uop = U_DMA2;
			6'd10:   s.uop = U_FXS;
			6'd11:   s.uop = U_MA2S;
			6'd12:   begin s.uop = U_DMP;  s.dsel = D_20; end
			6'd13:   begin s.uop = U_FXS;  s.dsel = D_20; end
			6'd14:   s.uop = U_MA2S;
			6'd15:   begin s.uop = U_DMP;  s.dsel = D_6; end
			6'd16:   begin s.uop = U_FXS;  s.dsel = D_6; end
			6'd17:   s.uop = U_MAS;
			6'd18:   s.uop = U_SLD;
			6'd19:   begin s.uop = U_DMA2; s.dsel = D_56; end
			6'd20:   begin s.uop = U_FXC;  s.dsel = D_56; end
			6'd21:   s.uop = U_MA2C;
			6'd22:   begin s.uop = U_DMP;  s.dsel = D_30; end
			6'd23:   begin s.uop = U_FXC;  s.dsel = D_30; end
			6'd24:   s.uop = U_MA2C;
			6'd25:   begin s.uop = U_DMP;  s.dsel = D_12; end
			6'd26:   begin s.uop = U_FXC;  s.dsel = D_12; end
			6'd27:   s.uop = U_MA2C;
			6'd28:   s.uop = U_CLAST;
			6'd29:   s.uop = U_QUAD;
			6'd30:   s.uop = U_XH;
			6'd31:   s.uop = U_XL;
			6'd32:   s.uop = U_XA;
			6'd33:   s.uop = U_YH;
			6'd34:   s.uop = U_YL;
			6'd35:   s.uop = U_YA;
			default: s.uop = U_NOP;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// Differential-drive odometry unit
// Dead-reckoning pose tracker fed with wheel encoder counts.
// ----------------------------------------------------------------------------
// One item at a time. An update item's result is loaded in the finish state
// that follows its 36 sequencer steps through the single shared 33x33
// multiplier (wheel scaling, heading product, polynomial sine and cosine with
// reciprocal divisions, two split products per axis).
// A set-pose item goes from acceptance straight to the finish state, which
// loads its result. in_ready is high only while no item is in work; a finished
// result waits in the output register without stalling input, though a further
// item cannot finish until that result is taken.
`default_nettype none

module differential_drive_odometry_unit #(
	parameter int COUNT_BITS    = ddo_pkg::DEF_COUNT_BITS,
	parameter int POS_FRAC_BITS = ddo_pkg::DEF_POS_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic signed [39:0] new_x,
	input  logic signed [39:0] new_y,
	input  logic        [31:0] new_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [39:0] pos_x,
	output logic signed [39:0] pos_y,
	output logic        [31:0] heading,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic        [23:0] cfg_data
);
	import ddo_pkg::*;

	cmd_t cmd;

	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ddo_datapath #(
		.COUNT_BITS    (COUNT_BITS),
		.POS_FRAC_BITS (POS_FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (op),
		.left_count  (left_count),
		.right_count (right_count),
		.new_x       (new_x),
		.new_y       (new_y),
		.new_heading (new_heading),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading     (heading)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_ctrl.sv
// ----------------------------------------------------------------------------
// Odometry controller
// Handshakes, step sequencing and result slot control.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	output logic          out_valid,
	input  logic          out_ready,
	output ddo_pkg::cmd_t cmd
);
	import ddo_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CALC, S_FIN} state_t;

	state_t     state_q;
	logic [5:0] step_q;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_free  = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.start    = accept;
		cmd.out_load = (state_q == S_FIN) & out_free;
		cmd.step     = (state_q == S_CALC) ? seq_step(step_q) : step_t'{U_NOP, D_42};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (accept)
						state_q <= op ? S_FIN : S_CALC;
				end
				S_CALC: begin
					step_q <= step_q + 6'd1;
					if (step_q == SEQ_LAST)
						state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_datapath.sv
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose state, configuration, shared multiplier and series evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_datapath #(
	parameter int COUNT_BITS    = ddo_pkg::DEF_COUNT_BITS,
	parameter int POS_FRAC_BITS = ddo_pkg::DEF_POS_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ddo_pkg::cmd_t       cmd,
	input  logic                op,
	input  logic signed [31:0]  left_count,
	input  logic signed [31:0]  right_count,
	input  logic signed [39:0]  new_x,
	input  logic signed [39:0]  new_y,
	input  logic        [31:0]  new_heading,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic        [23:0]  cfg_data,
	output logic signed [39:0]  pos_x,
	output logic signed [39:0]  pos_y,
	output logic        [31:0]  heading
);
	import ddo_pkg::*;

	localparam int SH     = POS_FRAC_BITS - 16;
	localparam int SHL    = (SH >= 0) ? SH : 0;
	localparam int SHR    = (SH < 0) ? -SH : 0;
	localparam int TERM_W = 47 + SHL;
	localparam int SUM_W  = TERM_W + 1;

	localparam logic signed [60:0] LIM_HI = 61'sd1 <<< 45;
	localparam logic signed [60:0] LIM_LO = -(61'sd1 <<< 45);
	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] POS_MIN = -SUM_W'(64'sd1 <<< (POS_W - 1));

	logic [CFG_W-1:0]      mpt_q, apm_q;
	logic [COUNT_BITS-1:0] prev_l_q, prev_r_q;
	logic signed [39:0]    x_q, y_q;
	logic [31:0]           hd_q;

	logic signed [32:0] del_l_q, del_r_q;
	logic signed [56:0] dl_q, ds_q;
	logic [48:0]        dd_q, plo_q;
	logic [1:0]         quad_q;
	logic               neg_q;
	logic [29:0]        ra_q, a_q, a2_q, dv_q;
	logic [30:0]        s_q, c_q;
	logic signed [31:0] tc_q, ts_q;
	logic signed [59:0] hp_q;
	logic signed [65:0] prod_q;

	logic signed [32:0] op_a, op_b;
	logic signed [65:0] mul;
	logic               mul_en;

	logic [COUNT_BITS-1:0] dif_l, dif_r;
	logic signed [56:0]    dr;
	logic signed [57:0]    dsum;
	logic [48:0]           p49, dd_n;
	logic [31:0]           mid, ma;
	logic [29:0]           ra_n;

	logic [5:0]  dcon;
	logic [29:0] qe, qfix;
	logic [35:0] qd, rem;

	logic signed [31:0] cv, sv;

	logic signed [37:0]       lt_sh;
	logic signed [60:0]       tsum, tacc, tcl;
	logic signed [TERM_W-1:0] term;
	logic signed [SUM_W-1:0]  psum;
	logic signed [39:0]       pos_old, pos_new;

	assign mul = op_a * op_b;

	always_comb begin
		op_a   = '0;
		op_b   = '0;
		mul_en = 1'b1;
		unique case (cmd.step.uop)
			U_ML:   begin op_a = del_l_q; op_b = {9'b0, mpt_q}; end
			U_MR:   begin op_a = del_r_q; op_b = {9'b0, mpt_q}; end
			U_P0:   begin op_a = {8'b0, dd_q[24:0]}; op_b = {9'b0, apm_q}; end
			U_P1:   begin op_a = {9'b0, dd_q[48:25]}; op_b = {9'b0, apm_q}; end
			U_A:    begin op_a = {3'b0, ra_q}; op_b = {1'b0, HALF_PI_Q30}; end
			U_A2:   begin op_a = {3'b0, prod_q[59:30]}; op_b = {3'b0, prod_q[59:30]}; end
			U_DMA2: begin op_a = {3'b0, a2_q}; op_b = {1'b0, recip(cmd.step.dsel)}; end
			U_DMP:  begin op_a = {3'b0, prod_q[59:30]}; op_b = {1'b0, recip(cmd.step.dsel)}; end
			U_MA2S: begin op_a = {3'b0, a2_q}; op_b = {2'b0, s_q}; end
			U_MA2C: begin op_a = {3'b0, a2_q}; op_b = {2'b0, c_q}; end
			U_MAS:  begin op_a = {3'b0, a_q}; op_b = {2'b0, s_q}; end
			U_XH:   begin op_a = 33'($signed(ds_q[56:28])); op_b = 33'(tc_q); end
			U_XL:   begin op_a = {5'b0, ds_q[27:0]}; op_b = 33'(tc_q); end
			U_YH:   begin op_a = 33'($signed(ds_q[56:28])); op_b = 33'(ts_q); end
			U_YL:   begin op_a = {5'b0, ds_q[27:0]}; op_b = 33'(ts_q); end
			default: mul_en = 1'b0;
		endcase
	end

	// count deltas wrap at the counter width
	always_comb begin
		dif_l = left_count[COUNT_BITS-1:0] - prev_l_q;
		dif_r = right_count[COUNT_BITS-1:0] - prev_r_q;
		dr    = prod_q[56:0];
		dsum  = 58'(dl_q) + 58'(dr);
		dd_n  = 49'(dr - dl_q);
	end

	// heading change, mid-step heading, quadrant and residual
	always_comb begin
		p49  = plo_q + {prod_q[23:0], 25'b0};
		mid  = hd_q + p49[48:17];
		ma   = mid + 32'h2000_0000;
		ra_n = ma[29] ? {1'b0, ma[28:0]} : (30'h2000_0000 - {1'b0, ma[28:0]});
	end

	// constant division: reciprocal estimate, one correction
	always_comb begin
		dcon = div_const(cmd.step.dsel);
		qe   = prod_q[63:34];
		qd   = 36'(qe) * 36'(dcon);
		rem  = {6'b0, dv_q} - qd;
		qfix = (rem >= 36'(dcon)) ? (qe + 30'd1) : qe;
	end

	always_comb begin
		cv = {1'b0, c_q};
		sv = neg_q ? -$signed({1'b0, s_q}) : $signed({1'b0, s_q});
	end

	// step term floor(ds * t / 2^30), clamped, rescaled, then saturating add
	always_comb begin
		lt_sh   = $signed(prod_q[65:28]);
		tsum    = 61'(hp_q) + 61'(lt_sh);
		tacc    = tsum >>> 2;
		if (tacc > LIM_HI)
			tcl = LIM_HI;
		else if (tacc < LIM_LO)
			tcl = LIM_LO;
		else
			tcl = tacc;
		term    = (TERM_W'(tcl) <<< SHL) >>> SHR;
		pos_old = (cmd.step.uop == U_YA) ? y_q : x_q;
		psum    = SUM_W'(pos_old) + SUM_W'(term);
		if (psum > POS_MAX)
			pos_new = POS_MAX[39:0];
		else if (psum < POS_MIN)
			pos_new = POS_MIN[39:0];
		else
			pos_new = psum[39:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q    <= MPT_RESET;
			apm_q    <= APM_RESET;
			prev_l_q <= '0;
			prev_r_q <= '0;
			x_q      <= '0;
			y_q      <= '0;
			hd_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MPT: mpt_q <= cfg_data;
					REG_APM: apm_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				if (op) begin
					x_q  <= new_x;
					y_q  <= new_y;
					hd_q <= new_heading;
				end else begin
					prev_l_q <= left_count[COUNT_BITS-1:0];
					prev_r_q <= right_count[COUNT_BITS-1:0];
				end
			end
			if (cmd.step.uop == U_MID)
				hd_q <= hd_q + p49[47:16];
			if (cmd.step.uop == U_XA)
				x_q <= pos_new;
			if (cmd.step.uop == U_YA)
				y_q <= pos_new;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_en)
			prod_q <= mul;
		if (cmd.start) begin
			del_l_q <= 33'($signed(dif_l));
			del_r_q <= 33'($signed(dif_r));
		end
		if (cmd.out_load) begin
			pos_x   <= x_q;
			pos_y   <= y_q;
			heading <= hd_q;
		end
		unique case (cmd.step.uop)
			U_MR:    dl_q <= prod_q[56:0];
			U_DS:    begin ds_q <= dsum[57:1]; dd_q <= dd_n; end
			U_P1:    plo_q <= prod_q[48:0];
			U_MID:   begin quad_q <= ma[31:30]; neg_q <= ~ma[29]; ra_q <= ra_n; end
			U_A2:    a_q <= prod_q[59:30];
			U_A2L:   a2_q <= prod_q[59:30];
			U_DMA2:  dv_q <= a2_q;
			U_DMP:   dv_q <= prod_q[59:30];
			U_FXS:   s_q <= 31'h4000_0000 - {1'b0, qfix};
			U_FXC:   c_q <= 31'h4000_0000 - {1'b0, qfix};
			U_SLD:   s_q <= {1'b0, prod_q[59:30]};
			U_CLAST: c_q <= 31'h4000_0000 - {2'b0, prod_q[59:31]};
			U_QUAD: begin
				unique case (quad_q)
					2'd0: begin tc_q <= cv;  ts_q <= sv;  end
					2'd1: begin tc_q <= -sv; ts_q <= cv;  end
					2'd2: begin tc_q <= -cv; ts_q <= -sv; end
					2'd3: begin tc_q <= sv;  ts_q <= -cv; end
					default: ;
				endcase
			end
			U_XL:    hp_q <= prod_q[59:0];
			U_YL:    hp_q <= prod_q[59:0];
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/ddo_checker.sv
// ----------------------------------------------------------------------------
// Odometry port checker
// Port-level temporal checks, bound to the odometry unit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_odometry_unit_macros.svh"

module ddo_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               op,
	input logic signed [39:0] new_x,
	input logic signed [39:0] new_y,
	input logic        [31:0] new_heading,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [39:0] pos_x,
	input logic signed [39:0] pos_y,
	input logic        [31:0] heading
);

	// a waiting result holds
	`ODO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pos_x) && $stable(pos_y) && $stable(heading))

	// one item in work at a time
	`ODO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a result is only produced as the block goes idle
	`ODO_ASSERT_NOW(a_result_idle, $rose(out_valid), in_ready)

	// set pose with a free result slot shows the loaded pose after the finish state
	`ODO_ASSERT_NEXT(a_load_pose, in_valid && in_ready && op && (!out_valid || out_ready), ##1 (out_valid && pos_x == $past(new_x, 2) && pos_y == $past(new_y, 2) && heading == $past(new_heading, 2)))

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (.*);

`default_nettype wire
